@@ rtl/core/url_component_splitter_macros.svh @@
// Assertion helpers shared by the splitter RTL.
`ifndef URL_COMPONENT_SPLITTER_MACROS_SVH
`define URL_COMPONENT_SPLITTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, disabled during reset.
`define UCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

@@ rtl/core/ucs_pkg.sv @@
package ucs_pkg;

   typedef enum logic [2:0] {
      PART_SCHEME   = 3'd0,
      PART_HOST     = 3'd1,
      PART_PORT     = 3'd2,
      PART_PATH     = 3'd3,
      PART_QUERY    = 3'd4,
      PART_FRAGMENT = 3'd5,
      TAG_DELIM     = 3'd6,
      TAG_LINE_END  = 3'd7
   } part_type;

   localparam logic [7:0]  CHAR_COLON    = 8'h3A;
   localparam logic [7:0]  CHAR_SLASH    = 8'h2F;
   localparam logic [7:0]  CHAR_QUESTION = 8'h3F;
   localparam logic [7:0]  CHAR_HASH     = 8'h23;
   localparam logic [7:0]  CHAR_LF       = 8'h0A;
   localparam logic [7:0]  CHAR_CR       = 8'h0D;
   localparam logic [7:0]  CHAR_ZERO     = 8'h30;
   localparam logic [7:0]  CHAR_NINE     = 8'h39;

   localparam logic [1:0]  SKIP_AFTER_SCHEME = 2'd2;
   localparam logic [15:0] PORT_MAX          = 16'hFFFF;

   typedef struct packed {
      logic [7:0] url_byte;
      logic       end_of_url;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  echo_byte;
      part_type    part_code;
      logic [15:0] port_number;
      logic        port_given;
      logic        url_done;
   } rsp_item_type;

endpackage

@@ rtl/core/ucs_req_if.sv @@
interface ucs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] url_byte;
   logic       end_of_url;

   modport source (output valid, output url_byte, output end_of_url, input ready);
   modport sink   (input valid, input url_byte, input end_of_url, output ready);
endinterface

@@ rtl/core/ucs_rsp_if.sv @@
interface ucs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  echo_byte;
   logic [2:0]  part_code;
   logic [15:0] port_number;
   logic        port_given;
   logic        url_done;

   modport source (output valid, output echo_byte, output part_code, output port_number,
                   output port_given, output url_done, input ready);
   modport sink   (input valid, input echo_byte, input part_code, input port_number,
                   input port_given, input url_done, output ready);
endinterface

@@ rtl/core/url_component_splitter.sv @@
// Byte-serial URL splitter. Each byte transferred on req_chan comes back on rsp_chan,
// tagged with the URL part it belongs to, a delimiter, or an ignored line end; on the
// byte marked end_of_url the result also carries the saturated decimal port and whether
// a port was opened, and the parser returns to the scheme for the next URL. One byte is
// taken every cycle unless stalled, set by the single parse-state update per byte; a result
// passes through the input register, then the result register, before rsp_chan offers it, and
// back pressure on rsp_chan stalls req_chan only once both registers are full.
`include "url_component_splitter_macros.svh"

module url_component_splitter (
   input  logic  clock,
   input  logic  reset,
   ucs_req_if.sink   req_chan,
   ucs_rsp_if.source rsp_chan
);
   import ucs_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type result;
   logic         advance;
   logic         req_take;

   assign advance     = in_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign req_take    = req_chan.valid & req_chan.ready;
   assign in_valid_in = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_chan.ready);

   assign req_chan.ready = ~in_valid_ff | advance;

   ucs_classifier u_classifier (
      .clock  (clock),
      .reset  (reset),
      .take   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.url_byte   <= req_chan.url_byte;
         in_item_ff.end_of_url <= req_chan.end_of_url;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.echo_byte   = out_item_ff.echo_byte;
   assign rsp_chan.part_code   = out_item_ff.part_code;
   assign rsp_chan.port_number = out_item_ff.port_number;
   assign rsp_chan.port_given  = out_item_ff.port_given;
   assign rsp_chan.url_done    = out_item_ff.url_done;

   `UCS_ASSERT_NEXT(a_stalled_input_held, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `UCS_ASSERT_NOW(a_port_only_on_done, clock, reset,
      out_valid_ff && !out_item_ff.url_done,
      out_item_ff.port_number == 16'd0 && !out_item_ff.port_given)
   `UCS_ASSERT_NOW(a_port_needs_given, clock, reset,
      out_valid_ff && !out_item_ff.port_given, out_item_ff.port_number == 16'd0)

endmodule

@@ rtl/core/ucs_classifier.sv @@
`include "url_component_splitter_macros.svh"

module ucs_classifier (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  ucs_pkg::req_item_type item,
   output ucs_pkg::rsp_item_type result
);
   import ucs_pkg::*;

   part_type    part_ff,  part_in;
   logic [1:0]  skip_ff,  skip_in;
   logic [15:0] acc_ff,   acc_in;
   logic        stop_ff,  stop_in;
   logic        seen_ff,  seen_in;

   part_type    tag;
   logic [7:0]  c;
   logic        is_digit;
   logic [19:0] acc_times_ten;

   assign c             = item.url_byte;
   assign is_digit      = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign acc_times_ten = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                          + {16'd0, c[3:0]};

   always_comb begin
      part_in = part_ff;
      skip_in = skip_ff;
      acc_in  = acc_ff;
      stop_in = stop_ff;
      seen_in = seen_ff;
      tag     = part_ff;
      if (skip_ff != 2'd0) begin
         skip_in = skip_ff - 2'd1;
         tag     = TAG_DELIM;
      end else if (c == CHAR_LF || c == CHAR_CR) begin
         tag = TAG_LINE_END;
      end else begin
         unique case (part_ff)
            PART_SCHEME: begin
               tag = PART_SCHEME;
               if (c == CHAR_COLON) begin
                  skip_in = SKIP_AFTER_SCHEME;
                  part_in = PART_HOST;
                  tag     = TAG_DELIM;
               end
            end
            PART_HOST: begin
               tag = PART_HOST;
               if (c == CHAR_COLON) begin
                  part_in = PART_PORT;
                  seen_in = 1'b1;
                  tag     = TAG_DELIM;
               end else if (c == CHAR_SLASH) begin
                  part_in = PART_PATH;
                  tag     = TAG_DELIM;
               end
            end
            PART_PORT: begin
               tag = PART_PORT;
               if (c == CHAR_SLASH) begin
                  part_in = PART_PATH;
                  tag     = TAG_DELIM;
               end else if (c == CHAR_QUESTION) begin
                  part_in = PART_QUERY;
                  tag     = TAG_DELIM;
               end else if (c == CHAR_HASH) begin
                  part_in = PART_FRAGMENT;
                  tag     = TAG_DELIM;
               end else if (!stop_ff) begin
                  if (is_digit) begin
                     acc_in = (acc_times_ten > {4'd0, PORT_MAX}) ? PORT_MAX
                                                                 : acc_times_ten[15:0];
                  end else begin
                     stop_in = 1'b1;
                  end
               end
            end
            PART_PATH: begin
               tag = PART_PATH;
               if (c == CHAR_QUESTION) begin
                  part_in = PART_QUERY;
                  tag     = TAG_DELIM;
               end else if (c == CHAR_HASH) begin
                  part_in = PART_FRAGMENT;
                  tag     = TAG_DELIM;
               end
            end
            PART_QUERY: begin
               tag = PART_QUERY;
               if (c == CHAR_HASH) begin
                  part_in = PART_FRAGMENT;
                  tag     = TAG_DELIM;
               end
            end
            default: begin
               part_in = PART_FRAGMENT;
               tag     = PART_FRAGMENT;
            end
         endcase
      end

      result.echo_byte   = c;
      result.part_code   = tag;
      result.port_number = item.end_of_url ? acc_in : 16'd0;
      result.port_given  = item.end_of_url & seen_in;
      result.url_done    = item.end_of_url;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= PART_SCHEME;
         skip_ff <= 2'd0;
         acc_ff  <= 16'd0;
         stop_ff <= 1'b0;
         seen_ff <= 1'b0;
      end else if (take) begin
         if (item.end_of_url) begin
            part_ff <= PART_SCHEME;
            skip_ff <= 2'd0;
            acc_ff  <= 16'd0;
            stop_ff <= 1'b0;
            seen_ff <= 1'b0;
         end else begin
            part_ff <= part_in;
            skip_ff <= skip_in;
            acc_ff  <= acc_in;
            stop_ff <= stop_in;
            seen_ff <= seen_in;
         end
      end
   end

   `UCS_ASSERT_NOW(a_skip_only_in_host, clock, reset, skip_ff != 2'd0, part_ff == PART_HOST)
   `UCS_ASSERT_NOW(a_acc_needs_port, clock, reset, acc_ff != 16'd0, seen_ff)
   `UCS_ASSERT_NOW(a_stop_needs_port, clock, reset, stop_ff, seen_ff)

endmodule
